/* hw/rtl/csmac_pkg.sv */
// Shared types and constants for the carrier-sense half-duplex MAC.
// No dependencies; imported by csmac_delay, csma_half_duplex_mac and csmac_checker.
package csmac_pkg;

  // Field widths
  localparam int unsigned LevelW  = 16;
  localparam int unsigned MsW     = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned RandW   = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // Packed stream widths (whole bytes)
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 56;

  // Smoothing gain 0.3 in Q0.16
  localparam logic [14:0] GainQ16 = 15'd19661;

  // Item kind carried on the input tuser
  localparam logic OpLevel = 1'b0;
  localparam logic OpTick  = 1'b1;

  // MAC mode codes as seen on the result stream
  localparam logic [ModeW-1:0] ModeIdle    = 2'd0;
  localparam logic [ModeW-1:0] ModeBackoff = 2'd1;
  localparam logic [ModeW-1:0] ModeTx      = 2'd2;
  localparam logic [ModeW-1:0] ModeGuard   = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBusyLevel  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDitherMin  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDitherMax  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBackoffMin = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBackoffMax = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGuard      = 3'd5;

  // Result bit positions inside the output tdata
  localparam int unsigned OutModeLsb   = 0;
  localparam int unsigned OutSendBit   = 2;
  localparam int unsigned OutClearBit  = 3;
  localparam int unsigned OutPassBit   = 4;
  localparam int unsigned OutForcedBit = 5;

endpackage

/* hw/rtl/csma_half_duplex_mac.sv */
// Top level of the carrier-sense half-duplex MAC: input register, one-pass state update,
// output register. Depends on csmac_pkg and csmac_delay.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid_i/tready_o       tdata: rms, now, flags, random; tuser: op
//  m_axis   out  m_axis_tvalid_o/tready_i       tdata: mode, flags, three counters
//  cfg      in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// Result registered after input register; one item per cycle sustained unless m_axis stalls.
// All work on an item is one combinational pass (two 16-bit multiplies, adds, compares)
// between the input register and the result register, which also updates the MAC state.
// Input and result stages stall independently; a full, stalled result stage backs up the input.
// Reset clears MAC state, counters and valid flags, loads cfg defaults; cfg is always ready.
module csma_half_duplex_mac
  import csmac_pkg::*;
#(
  parameter int unsigned MAX_RETRIES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [15:0] chunk_rms, [47:16] now_ms, [48] queue_nonempty, [49] receiver_busy,
  // [50] playback_done, [66:51] random_draw, [71:67] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] op
  input  logic                s_axis_tuser_i,
  // Result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [1:0] mac_mode, [2] send_frame, [3] clear_receiver, [4] pass_samples,
  // [5] forced_send, [21:6] backoff_total, [37:22] forced_total,
  // [53:38] sent_total, [55:54] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned RetryW = $clog2(MAX_RETRIES + 1);
  localparam logic [RetryW-1:0] RetryMax = RetryW'(MAX_RETRIES);

  typedef enum logic [ModeW-1:0] {
    ST_IDLE    = ModeIdle,
    ST_BACKOFF = ModeBackoff,
    ST_TX      = ModeTx,
    ST_GUARD   = ModeGuard
  } mode_e;

  // Configuration registers
  logic [CfgW-1:0] busy_level_q, dither_min_q, dither_max_q;
  logic [CfgW-1:0] backoff_min_q, backoff_max_q, guard_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_level_q  <= 16'd3277;
      dither_min_q  <= 16'd10;
      dither_max_q  <= 16'd100;
      backoff_min_q <= 16'd200;
      backoff_max_q <= 16'd1000;
      guard_q       <= 16'd300;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBusyLevel:  busy_level_q  <= cfg_data_i;
        RegDitherMin:  dither_min_q  <= cfg_data_i;
        RegDitherMax:  dither_max_q  <= cfg_data_i;
        RegBackoffMin: backoff_min_q <= cfg_data_i;
        RegBackoffMax: backoff_max_q <= cfg_data_i;
        RegGuard:      guard_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic               in_valid_q;
  logic               op_q;
  logic [LevelW-1:0]  rms_q;
  logic [TimeW-1:0]   now_q;
  logic               queued_q, rx_busy_q, played_q;
  logic [RandW-1:0]   rnd_q;
  logic               advance;
  logic               out_valid_q;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      op_q      <= s_axis_tuser_i;
      rms_q     <= s_axis_tdata_i[15:0];
      now_q     <= s_axis_tdata_i[47:16];
      queued_q  <= s_axis_tdata_i[48];
      rx_busy_q <= s_axis_tdata_i[49];
      played_q  <= s_axis_tdata_i[50];
      rnd_q     <= s_axis_tdata_i[66:51];
    end
  end

  // MAC state
  mode_e             mode_q, mode_d;
  logic [TimeW-1:0]  deadline_q, deadline_d;
  logic [RetryW-1:0] retries_q, retries_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [CountW-1:0] backoff_cnt_q, backoff_cnt_d;
  logic [CountW-1:0] forced_cnt_q, forced_cnt_d;
  logic [CountW-1:0] sent_cnt_q, sent_cnt_d;
  logic              send_d, clear_d, pass_d, forced_d;

  // Delay range follows the mode: dither from idle, backoff in backoff, fixed guard after tx
  logic [MsW-1:0]   dly_lo, dly_hi;
  logic [TimeW-1:0] dly_deadline;

  always_comb begin
    case (mode_q)
      ST_IDLE: begin
        dly_lo = dither_min_q;
        dly_hi = dither_max_q;
      end
      ST_BACKOFF: begin
        dly_lo = backoff_min_q;
        dly_hi = backoff_max_q;
      end
      default: begin
        dly_lo = guard_q;
        dly_hi = guard_q;
      end
    endcase
  end

  csmac_delay u_delay (
    .lo_i      (dly_lo),
    .hi_i      (dly_hi),
    .rnd_i     (rnd_q),
    .now_i     (now_q),
    .deadline_o(dly_deadline)
  );

  // Level smoothing: avg += floor(gain * (rms - avg))
  logic signed [LevelW:0]    diff;
  logic signed [LevelW+15:0] scaled;
  logic [LevelW-1:0]         level_new;

  assign diff      = $signed({1'b0, rms_q}) - $signed({1'b0, level_q});
  assign scaled    = diff * $signed({1'b0, GainQ16});
  assign level_new = level_q + scaled[LevelW+15:16];

  logic busy, expired;
  assign busy    = rx_busy_q || (level_q > busy_level_q);
  assign expired = now_q >= deadline_q;

  // Next state and result flags
  always_comb begin
    mode_d        = mode_q;
    deadline_d    = deadline_q;
    retries_d     = retries_q;
    level_d       = level_q;
    backoff_cnt_d = backoff_cnt_q;
    forced_cnt_d  = forced_cnt_q;
    sent_cnt_d    = sent_cnt_q;
    send_d        = 1'b0;
    clear_d       = 1'b0;
    pass_d        = 1'b0;
    forced_d      = 1'b0;
    if (op_q == OpLevel) begin
      level_d = level_new;
      pass_d  = (mode_q == ST_IDLE) || (mode_q == ST_BACKOFF);
    end else begin
      unique case (mode_q)
        ST_IDLE: begin
          if (queued_q) begin
            mode_d     = ST_BACKOFF;
            deadline_d = dly_deadline;
          end
        end
        ST_BACKOFF: begin
          if (expired) begin
            if (!queued_q) begin
              mode_d    = ST_IDLE;
              retries_d = '0;
            end else if (busy && (retries_q < RetryMax)) begin
              deadline_d    = dly_deadline;
              backoff_cnt_d = backoff_cnt_q + 1'b1;
              retries_d     = retries_q + 1'b1;
            end else begin
              if (retries_q >= RetryMax) begin
                forced_cnt_d = forced_cnt_q + 1'b1;
                forced_d     = 1'b1;
              end
              retries_d  = '0;
              send_d     = 1'b1;
              sent_cnt_d = sent_cnt_q + 1'b1;
              mode_d     = ST_TX;
              clear_d    = 1'b1;
            end
          end
        end
        ST_TX: begin
          if (played_q) begin
            mode_d     = ST_GUARD;
            deadline_d = dly_deadline;
          end
        end
        ST_GUARD: begin
          if (expired) begin
            clear_d = 1'b1;
            mode_d  = ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ST_IDLE;
      deadline_q    <= '0;
      retries_q     <= '0;
      level_q       <= '0;
      backoff_cnt_q <= '0;
      forced_cnt_q  <= '0;
      sent_cnt_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (advance) begin
        mode_q        <= mode_d;
        deadline_q    <= deadline_d;
        retries_q     <= retries_d;
        level_q       <= level_d;
        backoff_cnt_q <= backoff_cnt_d;
        forced_cnt_q  <= forced_cnt_d;
        sent_cnt_q    <= sent_cnt_d;
        out_valid_q   <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register
  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {2'b00, sent_cnt_d, forced_cnt_d, backoff_cnt_d,
                     forced_d, pass_d, clear_d, send_d, mode_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

/* hw/rtl/csmac_delay.sv */
// Random delay draw and saturating deadline: now + lo + (((hi - lo) * rnd) >> 16).
// Depends on csmac_pkg.
module csmac_delay
  import csmac_pkg::*;
(
  input  logic [MsW-1:0]   lo_i,
  input  logic [MsW-1:0]   hi_i,
  input  logic [RandW-1:0] rnd_i,
  input  logic [TimeW-1:0] now_i,
  output logic [TimeW-1:0] deadline_o
);

  logic [MsW-1:0]       span;
  logic [MsW+RandW-1:0] prod;
  logic [MsW-1:0]       delay;
  logic [TimeW:0]       sum;

  // Scaled span; a maximum below the minimum gives the minimum
  assign span  = (hi_i < lo_i) ? '0 : (hi_i - lo_i);
  assign prod  = span * rnd_i;
  assign delay = lo_i + prod[MsW+RandW-1:RandW];

  // Deadline saturates at the top of the time range
  assign sum        = {1'b0, now_i} + {{(TimeW+1-MsW){1'b0}}, delay};
  assign deadline_o = sum[TimeW] ? '1 : sum[TimeW-1:0];

endmodule

/* hw/rtl/csmac_checker.sv */
// Port-level checks for csma_half_duplex_mac, attached with a bind.
// Depends on csmac_pkg.
module csmac_checker
  import csmac_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [ModeW-1:0] mode;
  logic             send, clr, pass, forced;

  assign mode   = m_axis_tdata_o[OutModeLsb +: ModeW];
  assign send   = m_axis_tdata_o[OutSendBit];
  assign clr    = m_axis_tdata_o[OutClearBit];
  assign pass   = m_axis_tdata_o[OutPassBit];
  assign forced = m_axis_tdata_o[OutForcedBit];

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // A send always leaves the MAC transmitting and resets the receiver
  a_send_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && send |-> (mode == ModeTx) && clr)
    else $error("send without transmit mode");

  // A forced send is a send
  a_forced_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && forced |-> send)
    else $error("forced flag without send");

  // Passing samples happens only on level reports, which never act
  a_pass_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && pass |-> !send && !clr &&
      ((mode == ModeIdle) || (mode == ModeBackoff)))
    else $error("pass flag on an acting result");

endmodule

bind csma_half_duplex_mac csmac_checker u_csmac_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

/* test/csma_half_duplex_mac_tb.sv */
// Testbench for csma_half_duplex_mac: directed cases, then random tick and level traffic
// checked against a cycle-free model of the MAC. Depends on csmac_pkg and the MAC RTL.
`timescale 1ns / 1ps

module csma_half_duplex_mac_tb;
  import csmac_pkg::*;

  localparam int unsigned BusyRetryLimit = 8;
  localparam int unsigned SmoothGain     = 19661;
  localparam time         TimeoutNs      = 2_000_000;

  // One input transaction, unpacked
  typedef struct packed {
    logic              op;
    logic [LevelW-1:0] rms;
    logic [TimeW-1:0]  now_ms;
    logic              queued;
    logic              rx_busy;
    logic              played;
    logic [RandW-1:0]  draw;
  } mac_item_t;

  // One status report from the MAC
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic              send;
    logic              clear;
    logic              pass;
    logic              forced;
    logic [CountW-1:0] backoff_total;
    logic [CountW-1:0] forced_total;
    logic [CountW-1:0] sent_total;
  } mac_status_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  csma_half_duplex_mac #(
    .MAX_RETRIES(BusyRetryLimit)
  ) DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // MAC model state and register copy
  logic [CfgW-1:0]   mac_cfg [0:5];
  logic [ModeW-1:0]  mac_mode;
  logic [TimeW-1:0]  mac_deadline;
  logic [3:0]        mac_retries;
  logic [LevelW-1:0] mac_level;
  logic [CountW-1:0] mac_backoffs;
  logic [CountW-1:0] mac_forceds;
  logic [CountW-1:0] mac_sends;

  // Expected status reports, oldest first, in a small ring
  mac_status_t status_due [0:15];
  logic [3:0]  due_wr = '0;
  logic [3:0]  due_rd = '0;
  int unsigned due_count = 0;

  // Stimulus control and bookkeeping
  bit               feed_paced;
  bit               drain_paced;
  int unsigned      busy_pct;
  logic [TimeW-1:0] wall_ms;
  int unsigned      hold_left;
  int unsigned      items_sent, ticks_sent, levels_sent, reg_writes;
  int unsigned      results_seen, frames_sent, frames_forced, busy_backoffs;
  int unsigned      mismatches;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d status reports outstanding", due_count);
    $display("[csma_half_duplex_mac] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  function automatic void reset_mac_model();
    mac_cfg[RegBusyLevel]  = 16'd3277;
    mac_cfg[RegDitherMin]  = 16'd10;
    mac_cfg[RegDitherMax]  = 16'd100;
    mac_cfg[RegBackoffMin] = 16'd200;
    mac_cfg[RegBackoffMax] = 16'd1000;
    mac_cfg[RegGuard]      = 16'd300;
    mac_mode     = ModeIdle;
    mac_deadline = '0;
    mac_retries  = '0;
    mac_level    = '0;
    mac_backoffs = '0;
    mac_forceds  = '0;
    mac_sends    = '0;
  endfunction

  // Deadline arithmetic saturates at the top of the time range
  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] base, logic [TimeW-1:0] dly);
    logic [TimeW:0] sum;
    sum = {1'b0, base} + {1'b0, dly};
    return sum[TimeW] ? '1 : sum[TimeW-1:0];
  endfunction

  // lo + ((hi - lo) * frac) >> 16; a reversed range gives lo
  function automatic logic [TimeW-1:0] random_delay(logic [MsW-1:0] lo, logic [MsW-1:0] hi,
                                                    logic [RandW-1:0] frac);
    logic [MsW-1:0] span;
    logic [31:0]    scaled;
    if (hi < lo) return {16'd0, lo};
    span   = hi - lo;
    scaled = {16'd0, span} * {16'd0, frac};
    return {16'd0, lo} + (scaled >> 16);
  endfunction

  // Applies one accepted item to the model and returns the status it must produce
  function automatic mac_status_t mac_next_status(mac_item_t it);
    mac_status_t st;
    longint      diff, scaled, sum;
    logic        busy;
    st = '0;
    if (it.op == OpLevel) begin
      // smoothed level, difference scaled by 0.3 and floored
      diff   = longint'(it.rms) - longint'(mac_level);
      scaled = (diff * SmoothGain) >>> 16;
      sum    = longint'(mac_level) + scaled;
      mac_level = sum[LevelW-1:0];
      st.pass = (mac_mode == ModeIdle) || (mac_mode == ModeBackoff);
    end else begin
      case (mac_mode)
        ModeIdle: begin
          if (it.queued) begin
            mac_mode     = ModeBackoff;
            mac_deadline = sat_add(it.now_ms, random_delay(mac_cfg[RegDitherMin],
                                                           mac_cfg[RegDitherMax], it.draw));
          end
        end
        ModeBackoff: begin
          if (it.now_ms >= mac_deadline) begin
            if (!it.queued) begin
              mac_mode    = ModeIdle;
              mac_retries = '0;
            end else begin
              busy = it.rx_busy || (mac_level > mac_cfg[RegBusyLevel]);
              if (busy && mac_retries < BusyRetryLimit) begin
                mac_deadline = sat_add(it.now_ms, random_delay(mac_cfg[RegBackoffMin],
                                                               mac_cfg[RegBackoffMax], it.draw));
                mac_backoffs = mac_backoffs + 1'b1;
                mac_retries  = mac_retries + 1'b1;
              end else begin
                if (mac_retries >= BusyRetryLimit) begin
                  mac_forceds = mac_forceds + 1'b1;
                  st.forced   = 1'b1;
                end
                mac_retries = '0;
                mac_sends   = mac_sends + 1'b1;
                mac_mode    = ModeTx;
                st.send     = 1'b1;
                st.clear    = 1'b1;
              end
            end
          end
        end
        ModeTx: begin
          if (it.played) begin
            mac_mode     = ModeGuard;
            mac_deadline = sat_add(it.now_ms, {16'd0, mac_cfg[RegGuard]});
          end
        end
        default: begin
          if (it.now_ms >= mac_deadline) begin
            mac_mode = ModeIdle;
            st.clear = 1'b1;
          end
        end
      endcase
    end
    st.mode          = mac_mode;
    st.backoff_total = mac_backoffs;
    st.forced_total  = mac_forceds;
    st.sent_total    = mac_sends;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (all tasks start and end just after a falling edge)
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap(bit paced);
    int unsigned roll;
    if (!paced) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result-side backpressure
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready_i = 1'b0;
      hold_left--;
    end else begin
      hold_left = pick_gap(drain_paced);
      m_axis_tready_i = (hold_left == 0);
      if (hold_left != 0) hold_left--;
    end
  end

  task automatic send_mac_item(input mac_item_t it);
    mac_status_t st;
    int unsigned gap;
    gap = pick_gap(feed_paced);
    repeat (gap) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = it.op;
    s_axis_tdata_i  = {5'd0, it.draw, it.played, it.rx_busy, it.queued, it.now_ms, it.rms};
    do @(posedge clk_i); while (!s_axis_tready_o);
    st = mac_next_status(it);
    status_due[due_wr] = st;
    due_wr++;
    due_count++;
    items_sent++;
    if (it.op == OpTick) ticks_sent++;
    else levels_sent++;
    frames_sent   += st.send;
    frames_forced += st.forced;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  // Waits until every status report has come back and the pipeline is quiet
  task automatic settle();
    while (due_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    mac_cfg[idx] = val;
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic program_mac(input logic [CfgW-1:0] busy_lvl, dmin, dmax, bmin, bmax, guard);
    settle();
    write_reg(RegBusyLevel, busy_lvl);
    write_reg(RegDitherMin, dmin);
    write_reg(RegDitherMax, dmax);
    write_reg(RegBackoffMin, bmin);
    write_reg(RegBackoffMax, bmax);
    write_reg(RegGuard, guard);
  endtask

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  function automatic mac_item_t tick_item(logic [TimeW-1:0] t, logic q, logic rxb, logic done,
                                          logic [RandW-1:0] frac);
    mac_item_t it;
    it.op      = OpTick;
    it.rms     = LevelW'($urandom);
    it.now_ms  = t;
    it.queued  = q;
    it.rx_busy = rxb;
    it.played  = done;
    it.draw    = frac;
    return it;
  endfunction

  function automatic mac_item_t level_item(logic [LevelW-1:0] lvl);
    mac_item_t it;
    it.op      = OpLevel;
    it.rms     = lvl;
    it.now_ms  = $urandom;
    it.queued  = 1'($urandom_range(0, 1));
    it.rx_busy = 1'($urandom_range(0, 1));
    it.played  = 1'($urandom_range(0, 1));
    it.draw    = RandW'($urandom);
    return it;
  endfunction

  // Random item steered by the model so that deadlines are hit, missed and met exactly
  function automatic mac_item_t random_mac_item();
    mac_item_t   it;
    int unsigned roll;
    logic [TimeW-1:0] t;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // noise: every field random
      it = level_item(LevelW'($urandom));
      it.op = 1'($urandom_range(0, 1));
      return it;
    end
    if (roll < 35) begin
      case ($urandom_range(0, 3))
        0: return level_item(mac_cfg[RegBusyLevel] + 16'($urandom_range(0, 200)) - 16'd100);
        1: return level_item($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        default: return level_item(LevelW'($urandom));
      endcase
    end
    roll = $urandom_range(0, 9);
    if ((mac_mode == ModeBackoff || mac_mode == ModeGuard) && roll < 5)
      t = sat_add(mac_deadline, $urandom_range(0, 3));
    else if ((mac_mode == ModeBackoff || mac_mode == ModeGuard) && roll < 7)
      t = mac_deadline - $urandom_range(1, 50);
    else
      t = wall_ms + $urandom_range(0, 400);
    wall_ms = t;
    it = tick_item(t, $urandom_range(0, 99) < 88, $urandom_range(0, 99) < busy_pct,
                   1'($urandom_range(0, 1)),
                   ($urandom_range(0, 9) == 0) ? {RandW{$urandom_range(0, 1) == 1}} :
                                                 RandW'($urandom));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_status
    mac_status_t seen, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen.mode          = m_axis_tdata_o[OutModeLsb +: ModeW];
      seen.send          = m_axis_tdata_o[OutSendBit];
      seen.clear         = m_axis_tdata_o[OutClearBit];
      seen.pass          = m_axis_tdata_o[OutPassBit];
      seen.forced        = m_axis_tdata_o[OutForcedBit];
      seen.backoff_total = m_axis_tdata_o[6 +: CountW];
      seen.forced_total  = m_axis_tdata_o[22 +: CountW];
      seen.sent_total    = m_axis_tdata_o[38 +: CountW];
      results_seen++;
      if (due_count == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: status report with none expected: %p", $realtime, seen);
      end else begin
        want = status_due[due_rd];
        due_rd++;
        due_count--;
        if (seen != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: report %0d mismatch\n  expected mode=%0d send=%0d clear=%0d pass=%0d",
                      " forced=%0d backoffs=%0d forced_total=%0d sent=%0d\n",
                      "  actual   mode=%0d send=%0d clear=%0d pass=%0d",
                      " forced=%0d backoffs=%0d forced_total=%0d sent=%0d"},
                     $realtime, results_seen,
                     want.mode, want.send, want.clear, want.pass, want.forced,
                     want.backoff_total, want.forced_total, want.sent_total,
                     seen.mode, seen.send, seen.clear, seen.pass, seen.forced,
                     seen.backoff_total, seen.forced_total, seen.sent_total);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full cycle on a quiet channel: dither, send, playback, guard; then an abandoned wait
  task automatic test_quiet_send();
    feed_paced  = 1'b1;
    drain_paced = 1'b1;
    send_mac_item(tick_item(32'd0, 1'b1, 1'b0, 1'b0, 16'hFFFF));
    send_mac_item(tick_item(mac_deadline - 32'd1, 1'b1, 1'b0, 1'b0, RandW'($urandom)));
    send_mac_item(level_item(16'h0000));
    send_mac_item(tick_item(mac_deadline, 1'b1, 1'b0, 1'b0, RandW'($urandom)));
    send_mac_item(level_item(16'h0000));
    send_mac_item(tick_item(mac_deadline + 32'd1, 1'b1, 1'b0, 1'b0, RandW'($urandom)));
    send_mac_item(tick_item(mac_deadline + 32'd2, 1'b1, 1'b0, 1'b1, RandW'($urandom)));
    send_mac_item(level_item(16'h0000));
    send_mac_item(tick_item(mac_deadline - 32'd1, 1'b0, 1'b0, 1'b1, RandW'($urandom)));
    send_mac_item(tick_item(mac_deadline, 1'b0, 1'b1, 1'b1, RandW'($urandom)));
    send_mac_item(tick_item(mac_deadline + 32'd1, 1'b0, 1'b0, 1'b0, RandW'($urandom)));
    // empty queue when the dither ends
    send_mac_item(tick_item(mac_deadline + 32'd2, 1'b1, 1'b0, 1'b0, 16'h0000));
    send_mac_item(tick_item(mac_deadline, 1'b0, 1'b0, 1'b0, RandW'($urandom)));
  endtask

  // Level swings between the extremes; falling steps round toward minus infinity
  task automatic test_level_smoothing();
    send_mac_item(level_item(16'hFFFF));
    send_mac_item(level_item(16'h0000));
    send_mac_item(level_item(16'h0001));
  endtask

  // Busy channel at the top of the time range: reversed dither range, saturated
  // deadlines, every retry used up and then a forced send
  task automatic test_forced_send();
    program_mac(16'd3277, 16'd500, 16'd20, 16'd0, 16'hFFFF, 16'd300);
    send_mac_item(tick_item(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, RandW'($urandom)));
    repeat (BusyRetryLimit + 1)
      send_mac_item(tick_item(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, RandW'($urandom)));
  endtask

  task automatic run_traffic(input int unsigned n, input bit paced, input int unsigned bpct,
                             input logic [TimeW-1:0] start_ms);
    feed_paced  = paced;
    drain_paced = paced;
    busy_pct    = bpct;
    wall_ms     = start_ms;
    repeat (n) send_mac_item(random_mac_item());
  endtask

  // Random traffic under default, all-zero, all-ones and random register settings
  task automatic test_random_traffic();
    program_mac(16'd3277, 16'd10, 16'd100, 16'd200, 16'd1000, 16'd300);
    run_traffic(212, 1'b0, 30, 32'd1000);
    program_mac(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_traffic(212, 1'b1, 20, 32'd0);
    program_mac(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(212, 1'b1, 60, 32'hFFFF_0000);
    program_mac(CfgW'($urandom_range(0, 6000)), CfgW'($urandom), CfgW'($urandom),
                CfgW'($urandom), CfgW'($urandom), CfgW'($urandom));
    run_traffic(214, 1'b1, 85, $urandom);
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OpLevel;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = RegBusyLevel;
    cfg_data_i      = '0;
    reset_mac_model();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_quiet_send();
    test_level_smoothing();
    test_forced_send();
    test_random_traffic();

    for (int n = 0; n < 2000 && due_count != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (due_count != 0) begin
      $display("%0d status reports never arrived", due_count);
      mismatches += due_count;
    end
    busy_backoffs = mac_backoffs;
    $display("Covered %0d items (%0d ticks, %0d level reports), %0d register writes, %0d reports",
             items_sent, ticks_sent, levels_sent, reg_writes, results_seen);
    $display("MAC activity: %0d frames sent, %0d forced, %0d busy backoffs (16-bit count)",
             frames_sent, frames_forced, busy_backoffs);
    if (mismatches == 0) begin
      $display("[csma_half_duplex_mac] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[csma_half_duplex_mac] ERROR");
    end
    $finish;
  end

endmodule
